### hdl/bhn_pkg.sv
// Shared types, constants and the helper function of the block headroom normalizer.
package bhn_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int MAG_W               = 15;
    localparam int SHIFT_W             = 4;
    localparam int DEFAULT_BLOCK_DEPTH = 64;

    localparam logic [SHIFT_W-1:0] MAX_HEADROOM = 4'd14;
    localparam logic [SHIFT_W-1:0] UNIT_SHIFT   = 4'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [SHIFT_W-1:0]         shift_amount;
        logic                       last_out;
        logic                       overflowed;
    } out_item_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_NORM,
        S_READ,
        S_EMIT
    } bhn_state_t;

    // Absolute value of a Q15 sample, with the most negative code saturating.
    function automatic logic [MAG_W-1:0] sat_abs(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] neg;
        neg = SAMPLE_W'(-s);
        if (s == {1'b1, {(SAMPLE_W-1){1'b0}}})
        begin
            return {MAG_W{1'b1}};
        end
        else if (s[SAMPLE_W-1])
        begin
            return neg[MAG_W-1:0];
        end
        else
        begin
            return s[MAG_W-1:0];
        end
    endfunction

endpackage

### hdl/bhn_mem.sv
// Sample store: one write port and one registered read port.
module bhn_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [bhn_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [bhn_pkg::SAMPLE_W-1:0]  rd_data
);
    import bhn_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/bhn_shifter.sv
// Shared left shifter used for the headroom search and for scaling each output.
module bhn_shifter (
    input  logic [bhn_pkg::SAMPLE_W-1:0] operand,
    input  logic [bhn_pkg::SHIFT_W-1:0]  amount,
    output logic [bhn_pkg::SAMPLE_W-1:0] result
);
    import bhn_pkg::*;

    always_comb
    begin
        result = operand << amount;
    end

endmodule

### hdl/block_headroom_normalizer_q15_top.sv
// Top level of the block headroom normalizer: sequencer, state and datapath.
// The block accepts samples only while loading, and it never stalls its input while loading.
// After the last sample, the headroom search moves the block maximum through the shared
// shifter one bit a cycle, counting one bit of headroom per step.
// Each output item is then read from the store, then shifted and held on the port until taken.
// Reset is asynchronous and clears the control state; the store contents are not cleared.
module block_headroom_normalizer_q15_top #(
    parameter int BLOCK_DEPTH = bhn_pkg::DEFAULT_BLOCK_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              samp_valid,
    output logic              samp_stall,
    input  bhn_pkg::in_item_t samp_item,
    output logic              norm_valid,
    input  logic              norm_stall,
    output bhn_pkg::out_item_t norm_item
);
    import bhn_pkg::*;

    // The count must be able to hold the depth itself, while the store address
    // only needs to reach the last entry.
    localparam int CNT_W  = $clog2(BLOCK_DEPTH + 1);
    localparam int ADDR_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

    bhn_state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [MAG_W-1:0]   max_reg, max_next;
    logic [MAG_W-1:0]   norm_reg, norm_next;
    logic [SHIFT_W-1:0] h_reg, h_next;
    logic               ovf_reg, ovf_next;

    logic               in_acc;
    logic               out_acc;
    logic               has_room;
    logic               norm_done;
    logic               last_item;
    logic [MAG_W-1:0]   in_abs;
    logic [MAG_W-1:0]   max_upd;

    logic                mem_wr_en;
    logic                mem_rd_en;
    logic [SAMPLE_W-1:0] mem_rd_data;

    logic [SAMPLE_W-1:0] sh_operand;
    logic [SHIFT_W-1:0]  sh_amount;
    logic [SAMPLE_W-1:0] sh_result;

    assign in_acc  = samp_valid && !samp_stall;
    assign out_acc = norm_valid && !norm_stall;

    assign has_room = count_reg < CNT_W'(BLOCK_DEPTH);
    assign in_abs   = sat_abs(samp_item.sample_in);
    assign max_upd  = (in_abs > max_reg) ? in_abs : max_reg;

    // The search stops once the top magnitude bit is set; a zero maximum keeps a shift of zero.
    assign norm_done = (norm_reg == '0) || norm_reg[MAG_W-1];
    assign last_item = rd_idx_reg == (count_reg - CNT_W'(1));

    assign mem_wr_en = in_acc && has_room;

    bhn_mem #(
        .DEPTH  (BLOCK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (samp_item.sample_in),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    // One shifter serves both phases: a one-bit step of the maximum while searching,
    // and the full block shift of the stored sample while emitting.
    bhn_shifter u_shifter (
        .operand (sh_operand),
        .amount  (sh_amount),
        .result  (sh_result)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc && samp_item.last_in)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (norm_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_acc)
                begin
                    state_next = last_item ? S_LOAD : S_READ;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        samp_stall = 1'b1;
        norm_valid = 1'b0;
        mem_rd_en  = 1'b0;
        sh_operand = mem_rd_data;
        sh_amount  = h_reg;
        case (state_reg)
            S_LOAD:
            begin
                samp_stall = 1'b0;
            end
            S_NORM:
            begin
                sh_operand = {1'b0, norm_reg};
                sh_amount  = UNIT_SHIFT;
            end
            S_READ:
            begin
                mem_rd_en = 1'b1;
            end
            S_EMIT:
            begin
                norm_valid = 1'b1;
            end
            default:
            begin
                samp_stall = 1'b1;
            end
        endcase
    end

    // The headroom guarantees that every stored sample fits after the shift,
    // so the shifter result needs no saturation.
    always_comb
    begin
        norm_item.sample_out   = sh_result;
        norm_item.shift_amount = h_reg;
        norm_item.last_out     = last_item;
        norm_item.overflowed   = ovf_reg;
    end

    // Datapath register updates.
    always_comb
    begin
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        max_next    = max_reg;
        norm_next   = norm_reg;
        h_next      = h_reg;
        ovf_next    = ovf_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    max_next = max_upd;
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (samp_item.last_in)
                    begin
                        norm_next   = max_upd;
                        h_next      = '0;
                        rd_idx_next = '0;
                    end
                end
            end
            S_NORM:
            begin
                if (!norm_done)
                begin
                    norm_next = sh_result[MAG_W-1:0];
                    h_next    = h_reg + SHIFT_W'(1);
                end
            end
            S_READ:
            begin
                rd_idx_next = rd_idx_reg;
            end
            S_EMIT:
            begin
                if (out_acc)
                begin
                    if (last_item)
                    begin
                        count_next = '0;
                        max_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            max_reg    <= '0;
            norm_reg   <= '0;
            h_reg      <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            max_reg    <= max_next;
            norm_reg   <= norm_next;
            h_reg      <= h_next;
            ovf_reg    <= ovf_next;
        end
    end

    // The headroom never grows beyond what a nonzero 15-bit maximum allows.
    a_headroom_range: assert property (@(posedge clk) disable iff (!rst_n)
        h_reg <= MAX_HEADROOM)
        else $error("headroom out of range");

    // The store never holds more samples than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BLOCK_DEPTH))
        else $error("sample count beyond depth");

    // An output item is only offered for a block that stored at least one sample.
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid |-> (count_reg != '0) && (rd_idx_reg < count_reg))
        else $error("output item without a stored sample");

    // Reading starts only after the maximum has been fully normalized.
    a_norm_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (norm_reg == '0) || norm_reg[MAG_W-1])
        else $error("emission started before headroom search finished");

    // Taking the final item of a block clears the block state and reopens the input.
    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && norm_item.last_out) |=> (count_reg == '0) && (max_reg == '0) && !samp_stall)
        else $error("block state not cleared after final item");

endmodule

### tb/tb_top.sv
// Self-checking testbench of the block headroom normalizer: directed table, then random blocks.
module tb_top;

    import bhn_pkg::*;

    // The block is built with its default depth, and the predictor keeps the same limit.
    localparam int BLOCK_DEPTH = DEFAULT_BLOCK_DEPTH;

    // Half of the 12-unit clock period, and the guard time for a hung run.
    localparam int HALF_PERIOD  = 6;
    localparam int GUARD_CYCLES = 200000;

    // Number of input items the random part aims for, counted from the start of the run.
    localparam int SAMPLE_GOAL = 210;

    // After the last expected item, the headroom search and store read could still be
    // busy, so the drain waits well past the longest headroom search.
    localparam int DRAIN_CYCLES = 40;

    // One row of the directed table. When has_want is set, the row is a one-sample block
    // whose single result is typed in by hand; otherwise the predictor decides.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       lst;
        logic                       has_want;
        out_item_t                  want;
    } stim_row_t;

    localparam int PLAN_ROWS = 19;

    localparam stim_row_t PLAN [PLAN_ROWS] = '{
        // One-sample blocks whose result can be read off directly.
        '{16'sh0000, 1'b1, 1'b1, '{16'sh0000, 4'd0, 1'b1, 1'b0}},          // all zero
        '{16'sh7FFF, 1'b1, 1'b1, '{16'sh7FFF, 4'd0, 1'b1, 1'b0}},          // positive full scale
        '{16'sh8000, 1'b1, 1'b1, '{16'sh8000, 4'd0, 1'b1, 1'b0}},          // most negative code
        '{16'sh0001, 1'b1, 1'b1, '{16'sh4000, MAX_HEADROOM, 1'b1, 1'b0}},  // smallest positive
        '{16'shFFFF, 1'b1, 1'b1, '{16'shC000, MAX_HEADROOM, 1'b1, 1'b0}},  // minus one
        '{16'sh4000, 1'b1, 1'b1, '{16'sh4000, 4'd0, 1'b1, 1'b0}},          // just at half scale
        '{16'sh3FFF, 1'b1, 1'b1, '{16'sh7FFE, UNIT_SHIFT, 1'b1, 1'b0}},    // just under half
        // A mixed small block.
        '{16'sh0100, 1'b0, 1'b0, '0},
        '{16'shFE00, 1'b0, 1'b0, '0},
        '{16'sh0003, 1'b1, 1'b0, '0},
        // An all-zero block of several samples.
        '{16'sh0000, 1'b0, 1'b0, '0},
        '{16'sh0000, 1'b0, 1'b0, '0},
        '{16'sh0000, 1'b1, 1'b0, '0},
        // The most negative code hidden among small values forces a zero shift.
        '{16'sh0005, 1'b0, 1'b0, '0},
        '{16'sh8000, 1'b0, 1'b0, '0},
        '{16'sh0007, 1'b1, 1'b0, '0},
        // A negative half-scale peak also leaves no headroom.
        '{16'shC000, 1'b0, 1'b0, '0},
        '{16'sh0064, 1'b0, 1'b0, '0},
        '{16'shFFFB, 1'b1, 1'b0, '0}
    };

    logic      clk;
    logic      rst_n;
    logic      samp_valid;
    logic      samp_stall;
    in_item_t  samp_item;
    logic      norm_valid;
    logic      norm_stall;
    out_item_t norm_item;

    // Predictor state: the samples held for the open block, its running peak magnitude,
    // and whether any sample was dropped because the store was full.
    logic signed [SAMPLE_W-1:0] held_q [$];
    logic [MAG_W-1:0]           held_peak;
    logic                       held_dropped;

    // Normalized items that the block still owes, oldest first.
    out_item_t normalized_q [$];
    out_item_t oldest;

    int  mismatches = 0;
    int  samples_sent;

    // While calm is set, neither side inserts idle cycles.
    logic calm;

    block_headroom_normalizer_q15_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .samp_valid (samp_valid),
        .samp_stall (samp_stall),
        .samp_item  (samp_item),
        .norm_valid (norm_valid),
        .norm_stall (norm_stall),
        .norm_item  (norm_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Magnitude of a Q15 sample; the most negative code is clipped to full scale.
    function automatic logic [MAG_W-1:0] q15_magnitude(input logic signed [SAMPLE_W-1:0] s);
        if (s == -16'sd32768)
        begin
            return 15'h7FFF;
        end
        else if (s < 0)
        begin
            return MAG_W'(-s);
        end
        else
        begin
            return MAG_W'(s);
        end
    endfunction

    // Headroom of a peak magnitude: the leading zeros within its 15 bits, or zero when
    // the peak itself is zero.
    function automatic logic [SHIFT_W-1:0] headroom_for(input logic [MAG_W-1:0] peak);
        logic [SHIFT_W-1:0] h;
        logic [MAG_W-1:0]   p;
        h = '0;
        p = peak;
        if (p == '0)
        begin
            return '0;
        end
        while (!p[MAG_W-1])
        begin
            p = p << 1;
            h = h + 1'b1;
        end
        return h;
    endfunction

    // Left shift of one sample with 16-bit saturation. The headroom is chosen so that the
    // clip never engages, but it is kept so a wrong headroom would show as a clipped value.
    function automatic logic signed [SAMPLE_W-1:0] scaled_sample(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [SHIFT_W-1:0]         h
    );
        logic signed [31:0] wide;
        wide = s;
        wide = wide <<< h;
        if (wide > 32767)
        begin
            wide = 32767;
        end
        else if (wide < -32768)
        begin
            wide = -32768;
        end
        return wide[SAMPLE_W-1:0];
    endfunction

    // Folds one accepted sample into the open block. On the marked sample it queues the
    // whole normalized block and clears the block state.
    task automatic fold_sample(input in_item_t it);
        logic [SHIFT_W-1:0] hr;
        out_item_t          r;
        if (held_q.size() < BLOCK_DEPTH)
        begin
            held_q.push_back(it.sample_in);
        end
        else
        begin
            held_dropped = 1'b1;
        end
        // A dropped sample still counts toward the peak.
        if (q15_magnitude(it.sample_in) > held_peak)
        begin
            held_peak = q15_magnitude(it.sample_in);
        end
        if (it.last_in)
        begin
            hr = headroom_for(held_peak);
            for (int i = 0; i < held_q.size(); i++)
            begin
                r.sample_out   = scaled_sample(held_q[i], hr);
                r.shift_amount = hr;
                r.last_out     = (i == held_q.size() - 1);
                r.overflowed   = held_dropped;
                normalized_q.push_back(r);
            end
            held_q.delete();
            held_peak    = '0;
            held_dropped = 1'b0;
        end
    endtask

    // Offers one sample and returns at the falling edge after it was taken. The caller is
    // always at a falling edge, so valid is written once per step. When has_want is set,
    // the hand-typed result replaces the one that the predictor queued for this item.
    task automatic send_sample(
        input in_item_t  it,
        input logic      has_want,
        input out_item_t want
    );
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 10)
            begin
                samp_valid <= 1'b0;
                @(negedge clk);
            end
        end
        samp_valid <= 1'b1;
        samp_item  <= it;
        @(posedge clk);
        while (samp_stall)
        begin
            @(posedge clk);
        end
        fold_sample(it);
        if (has_want)
        begin
            void'(normalized_q.pop_back());
            normalized_q.push_back(want);
        end
        samples_sent++;
        @(negedge clk);
    endtask

    // Holds the sender back until the block has delivered everything it owes.
    task automatic wait_drained();
        samp_valid <= 1'b0;
        @(negedge clk);
        while (normalized_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sends one random block of the given length with the marker on its final sample.
    // Most blocks are scaled to aim at a chosen headroom, so every shift from 0 to 14 is
    // reached; about a fifth are raw 16-bit noise.
    task automatic stream_block(input int len);
        int        goal;
        int        lim;
        int        v;
        logic      noisy;
        in_item_t  it;
        goal  = $urandom_range(0, MAX_HEADROOM);
        lim   = 32767 >> goal;
        noisy = ($urandom_range(0, 99) < 20);
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
            begin
                v = $urandom_range(0, 65535);
            end
            else if (goal == 0 && $urandom_range(0, 19) == 0)
            begin
                v = -32768;
            end
            else
            begin
                // Now and then hit the limit exactly so the headroom lands on its edge.
                v = ($urandom_range(0, 7) == 0) ? lim : $urandom_range(0, lim);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            it.sample_in = SAMPLE_W'(v);
            it.last_in   = (i == len - 1);
            send_sample(it, 1'b0, '0);
        end
    endtask

    // The result side: every accepted item is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && norm_valid && !norm_stall)
        begin
            if (normalized_q.size() == 0)
            begin
                $error("unexpected result item: sample_out=%0d shift_amount=%0d",
                       norm_item.sample_out, norm_item.shift_amount);
                mismatches++;
            end
            else
            begin
                oldest = normalized_q.pop_front();
                if (norm_item.sample_out !== oldest.sample_out)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           oldest.sample_out, norm_item.sample_out);
                    mismatches++;
                end
                if (norm_item.shift_amount !== oldest.shift_amount)
                begin
                    $error("shift_amount: expected %0d, got %0d",
                           oldest.shift_amount, norm_item.shift_amount);
                    mismatches++;
                end
                if (norm_item.last_out !== oldest.last_out)
                begin
                    $error("last_out: expected %0b, got %0b",
                           oldest.last_out, norm_item.last_out);
                    mismatches++;
                end
                if (norm_item.overflowed !== oldest.overflowed)
                begin
                    $error("overflowed: expected %0b, got %0b",
                           oldest.overflowed, norm_item.overflowed);
                    mismatches++;
                end
            end
        end
    end

    // The result side stalls with a probability of about one in ten, except during calm stretches.
    always @(negedge clk)
    begin
        norm_stall <= !calm && ($urandom_range(0, 99) < 10);
    end

    // A hung handshake ends the run here.
    initial
    begin
        #(2 * HALF_PERIOD * GUARD_CYCLES);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int blk;
        int len;
        rst_n        = 1'b0;
        samp_valid   = 1'b0;
        samp_item    = '0;
        calm         = 1'b0;
        held_peak    = '0;
        held_dropped = 1'b0;
        samples_sent = 0;
        blk          = 0;

        // Reset is held low from the start and released at a falling edge.
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: walk the table in order.
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            send_sample(in_item_t'{PLAN[r].smp, PLAN[r].lst}, PLAN[r].has_want,
                        PLAN[r].want);
        end

        // Let the block empty out completely before the random part starts.
        wait_drained();

        // Random part. Block one is a long block that runs with no idling on either side,
        // through its whole emission, block two is exactly full and block five overflows
        // the store. The rest are mostly short, with an occasional medium-length block.
        while (samples_sent < SAMPLE_GOAL)
        begin
            if (blk == 1)
            begin
                len = $urandom_range(20, 40);
            end
            else if (blk == 2)
            begin
                len = BLOCK_DEPTH;
            end
            else if (blk == 5)
            begin
                len = $urandom_range(BLOCK_DEPTH + 1, BLOCK_DEPTH + 6);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                len = $urandom_range(9, 20);
            end
            else
            begin
                len = $urandom_range(1, 8);
            end
            calm = (blk == 1);
            stream_block(len);
            // The calm block drains before idling resumes, so its results also arrive
            // without a stall.
            if (calm)
            begin
                wait_drained();
            end
            calm = 1'b0;
            // Occasionally pause the sender until every owed item has come back.
            if ($urandom_range(0, 9) == 0)
            begin
                wait_drained();
            end
            blk++;
        end

        // Wait for the last block, then give stray items time to show up.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
hdl/bhn_pkg.sv
hdl/bhn_mem.sv
hdl/bhn_shifter.sv
hdl/block_headroom_normalizer_q15_top.sv
tb/tb_top.sv
